// ===== sv/tse_pkg.sv =====
// tse_pkg: shared types and constants for the two-stack expression evaluator
// no dependencies
package tse_pkg;

    localparam logic [1:0] CMD_CHAR     = 2'd0;
    localparam logic [1:0] CMD_CHAR_END = 2'd1;
    localparam logic [1:0] CMD_END      = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic               error;
    } t_rsp;

    // datapath commands
    localparam logic [3:0] DC_NONE     = 4'd0;
    localparam logic [3:0] DC_CLEAR    = 4'd1;
    localparam logic [3:0] DC_DIGIT    = 4'd2;
    localparam logic [3:0] DC_FLUSH    = 4'd3;
    localparam logic [3:0] DC_PUSH_OP  = 4'd4;
    localparam logic [3:0] DC_POP_B    = 4'd5;
    localparam logic [3:0] DC_POP_OP   = 4'd6;
    localparam logic [3:0] DC_POP_A    = 4'd7;
    localparam logic [3:0] DC_APPLY    = 4'd8;
    localparam logic [3:0] DC_DIV_STEP = 4'd9;
    localparam logic [3:0] DC_PUSH_RES = 4'd10;
    localparam logic [3:0] DC_SUM_POP  = 4'd11;
    localparam logic [3:0] DC_SUM_ADD  = 4'd12;
    localparam logic [3:0] DC_FINISH   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] char_code;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_oper;
        logic is_rpar;
        logic opnd_empty;
        logic optr_empty;
        logic is_divide;
        logic div_done;
    } t_dp_sts;

endpackage

// ===== sv/tse_if.sv =====
// tse_if: valid/ready channel carrying one payload
// depends on nothing; payload type given as a type parameter
interface tse_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/two_stack_expression_evaluator_top.sv =====
// Expression evaluator taking one character per request on the input channel; a result
// leaves on the output channel only at end of feed. ')' walks a pop/apply/push sequence,
// and when the operator is / or % with a nonzero divisor it also runs the restoring
// divider, which retires one quotient bit a cycle. End of feed adds one reduction per
// queued operator and a pop and an add per operand for the final sum. The result sits
// in an output register, so a new request is taken while it waits.
// depends on tse_pkg, tse_if, tse_ctrl, tse_dp
module two_stack_expression_evaluator_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tse_if.sink   i_req,
    tse_if.source o_rsp
);
    import tse_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_rsp    rsp;
    logic    rsp_load;
    logic    r_out_valid;
    t_rsp    r_out;

    tse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.data),
        .o_req_ready (i_req.ready),
        .i_rsp_room  (!r_out_valid || o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tse_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp_load (rsp_load),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (rsp_load) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule

// ===== sv/tse_ctrl.sv =====
// tse_ctrl: sequencer for character, reduction and end-of-feed handling
// depends on tse_pkg
module tse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  tse_pkg::t_req    i_req,
    output logic             o_req_ready,
    input  logic             i_rsp_room,
    output tse_pkg::t_dp_cmd o_cmd,
    input  tse_pkg::t_dp_sts i_sts
);
    import tse_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHAR   = 4'd1;
    localparam logic [3:0] S_POP_B  = 4'd2;
    localparam logic [3:0] S_POP_OP = 4'd3;
    localparam logic [3:0] S_POP_A  = 4'd4;
    localparam logic [3:0] S_APPLY  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_PUSH   = 4'd7;
    localparam logic [3:0] S_EFLUSH = 4'd8;
    localparam logic [3:0] S_EREDUC = 4'd9;
    localparam logic [3:0] S_SUMPOP = 4'd10;
    localparam logic [3:0] S_SUMADD = 4'd11;
    localparam logic [3:0] S_FINISH = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_cmd;
    logic [7:0] r_char;
    logic       r_in_end, n_in_end;

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_end <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_end <= n_in_end;
        end
        if (o_req_ready && i_req_valid) begin
            r_cmd  <= i_req.cmd;
            r_char <= i_req.char_code;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_in_end        = r_in_end;
        o_cmd.op        = DC_NONE;
        o_cmd.char_code = r_char;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.cmd == CMD_CLEAR) begin
                        o_cmd.op = DC_CLEAR;
                    end else if (i_req.cmd == CMD_END) begin
                        n_state = S_EFLUSH;
                    end else begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                n_state = (r_cmd == CMD_CHAR_END) ? S_EFLUSH : S_IDLE;
                if (i_sts.is_digit) begin
                    o_cmd.op = DC_DIGIT;
                end else if (i_sts.is_oper) begin
                    o_cmd.op = DC_PUSH_OP;
                end else begin
                    o_cmd.op = DC_FLUSH;
                    if (i_sts.is_rpar) begin
                        n_state  = S_POP_B;
                        n_in_end = (r_cmd == CMD_CHAR_END);
                    end
                end
            end
            S_POP_B: begin
                o_cmd.op = DC_POP_B;
                n_state  = S_POP_OP;
            end
            S_POP_OP: begin
                o_cmd.op = DC_POP_OP;
                n_state  = S_POP_A;
            end
            S_POP_A: begin
                o_cmd.op = DC_POP_A;
                n_state  = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.op = DC_APPLY;
                n_state  = i_sts.is_divide ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                o_cmd.op = DC_DIV_STEP;
                if (i_sts.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.op = DC_PUSH_RES;
                n_state  = r_in_end ? S_EREDUC : S_IDLE;
            end
            S_EFLUSH: begin
                o_cmd.op = DC_FLUSH;
                n_state  = S_EREDUC;
            end
            S_EREDUC: begin
                n_in_end = 1'b1;
                n_state  = i_sts.optr_empty ? S_SUMPOP : S_POP_B;
            end
            S_SUMPOP: begin
                n_in_end = 1'b0;
                if (i_sts.opnd_empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = DC_SUM_POP;
                    n_state  = S_SUMADD;
                end
            end
            S_SUMADD: begin
                o_cmd.op = DC_SUM_ADD;
                n_state  = S_SUMPOP;
            end
            S_FINISH: begin
                if (i_rsp_room) begin
                    o_cmd.op = DC_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/tse_dp.sv =====
// tse_dp: stacks, digit accumulator, alu with iterative divider, sum register
// depends on tse_pkg
module tse_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tse_pkg::t_dp_cmd i_cmd,
    output tse_pkg::t_dp_sts o_sts,
    output logic             o_rsp_load,
    output tse_pkg::t_rsp    o_rsp
);
    import tse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [31:0] r_opnd_mem [STACK_DEPTH];
    logic [2:0]  r_optr_mem [STACK_DEPTH];
    logic [CW-1:0] r_opnd_cnt, r_optr_cnt;
    logic [31:0] r_acc, r_a, r_b, r_sum, r_res, r_rd;
    logic [2:0]  r_op;
    logic        r_in_num, r_err, r_bad;
    logic [31:0] r_quo, r_rem, r_dvd;
    logic [5:0]  r_cnt;
    logic        r_neg_q, r_neg_r;

    logic [7:0]  c;
    logic        digit;
    logic [2:0]  op_code;
    logic        oper;
    logic [32:0] trial;
    logic [31:0] ma, mb;

    assign c     = i_cmd.char_code;
    assign digit = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb begin
        oper    = 1'b1;
        op_code = OP_ADD;
        unique case (c)
            CH_PLUS:  op_code = OP_ADD;
            CH_MINUS: op_code = OP_SUB;
            CH_STAR:  op_code = OP_MUL;
            CH_SLASH: op_code = OP_DIV;
            CH_PCT:   op_code = OP_MOD;
            default:  oper = 1'b0;
        endcase
    end

    assign ma    = r_a[31] ? (32'd0 - r_a) : r_a;
    assign mb    = r_b[31] ? (32'd0 - r_b) : r_b;
    assign trial = {r_rem, r_dvd[31]} - {1'b0, r_b};

    assign o_sts.is_digit   = digit;
    assign o_sts.is_oper    = oper;
    assign o_sts.is_rpar    = (c == CH_RPAR);
    assign o_sts.opnd_empty = (r_opnd_cnt == '0);
    assign o_sts.optr_empty = (r_optr_cnt == '0);
    assign o_sts.is_divide  = !r_bad && ((r_op == OP_DIV) || (r_op == OP_MOD)) && (r_b != 0);
    assign o_sts.div_done   = (r_cnt == 6'd31);

    assign o_rsp_load  = (i_cmd.op == DC_FINISH);
    assign o_rsp.value = r_sum;
    assign o_rsp.error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opnd_cnt <= '0;
            r_optr_cnt <= '0;
            r_acc      <= '0;
            r_in_num   <= 1'b0;
            r_err      <= 1'b0;
            r_sum      <= '0;
        end else begin
            unique case (i_cmd.op)
                DC_CLEAR: begin
                    r_opnd_cnt <= '0;
                    r_optr_cnt <= '0;
                    r_acc      <= '0;
                    r_in_num   <= 1'b0;
                    r_err      <= 1'b0;
                end
                DC_DIGIT: begin
                    r_acc    <= (r_acc << 3) + (r_acc << 1) + {28'd0, c[3:0]};
                    r_in_num <= 1'b1;
                end
                DC_FLUSH: begin
                    if (r_in_num) begin
                        if (r_opnd_cnt == FULL) begin
                            r_err <= 1'b1;
                        end else begin
                            r_opnd_mem[r_opnd_cnt[AW-1:0]] <= r_acc;
                            r_opnd_cnt <= r_opnd_cnt + 1'b1;
                        end
                        r_in_num <= 1'b0;
                        r_acc    <= '0;
                    end
                end
                DC_PUSH_OP: begin
                    if ((r_in_num && (r_opnd_cnt == FULL)) || (r_optr_cnt == FULL)) begin
                        r_err <= 1'b1;
                    end
                    if (r_in_num) begin
                        if (r_opnd_cnt != FULL) begin
                            r_opnd_mem[r_opnd_cnt[AW-1:0]] <= r_acc;
                            r_opnd_cnt <= r_opnd_cnt + 1'b1;
                        end
                        r_in_num <= 1'b0;
                        r_acc    <= '0;
                    end
                    if (r_optr_cnt != FULL) begin
                        r_optr_mem[r_optr_cnt[AW-1:0]] <= op_code;
                        r_optr_cnt <= r_optr_cnt + 1'b1;
                    end
                end
                DC_POP_B: begin
                    r_bad <= (r_opnd_cnt == '0);
                    if (r_opnd_cnt != '0) begin
                        r_b        <= r_opnd_mem[r_opnd_cnt[AW-1:0] - 1'b1];
                        r_opnd_cnt <= r_opnd_cnt - 1'b1;
                    end
                end
                DC_POP_OP: begin
                    if (r_optr_cnt != '0) begin
                        r_op       <= r_optr_mem[r_optr_cnt[AW-1:0] - 1'b1];
                        r_optr_cnt <= r_optr_cnt - 1'b1;
                    end else begin
                        r_bad <= 1'b1;
                    end
                end
                DC_POP_A: begin
                    if (r_opnd_cnt != '0) begin
                        r_a        <= r_opnd_mem[r_opnd_cnt[AW-1:0] - 1'b1];
                        r_opnd_cnt <= r_opnd_cnt - 1'b1;
                    end else begin
                        r_bad <= 1'b1;
                    end
                end
                DC_APPLY: begin
                    r_dvd   <= ma;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_neg_q <= r_a[31] ^ r_b[31];
                    r_neg_r <= r_a[31];
                    r_b     <= mb;
                    if (r_bad || (((r_op == OP_DIV) || (r_op == OP_MOD)) && (r_b == '0))) begin
                        r_err <= 1'b1;
                    end
                    if (r_bad) begin
                        r_res <= '0;
                    end else begin
                        unique case (r_op)
                            OP_ADD:  r_res <= r_a + r_b;
                            OP_SUB:  r_res <= r_a - r_b;
                            OP_MUL:  r_res <= r_a * r_b;
                            default: r_res <= '0;
                        endcase
                    end
                end
                DC_DIV_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_dvd[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd31) begin
                        if (r_op == OP_DIV) begin
                            r_res <= r_neg_q ? (32'd0 - {r_quo[30:0], !trial[32]})
                                             : {r_quo[30:0], !trial[32]};
                        end else begin
                            r_res <= r_neg_r
                                ? (32'd0 - (trial[32] ? {r_rem[30:0], r_dvd[31]} : trial[31:0]))
                                : (trial[32] ? {r_rem[30:0], r_dvd[31]} : trial[31:0]);
                        end
                    end
                end
                DC_PUSH_RES: begin
                    if (r_opnd_cnt == FULL) begin
                        r_err <= 1'b1;
                    end else begin
                        r_opnd_mem[r_opnd_cnt[AW-1:0]] <= r_res;
                        r_opnd_cnt <= r_opnd_cnt + 1'b1;
                    end
                end
                DC_SUM_POP: begin
                    r_rd       <= r_opnd_mem[r_opnd_cnt[AW-1:0] - 1'b1];
                    r_opnd_cnt <= r_opnd_cnt - 1'b1;
                end
                DC_SUM_ADD: begin
                    r_sum <= r_sum + r_rd;
                end
                DC_FINISH: begin
                    r_opnd_mem[0] <= r_sum;
                    r_opnd_cnt    <= CW'(1);
                    r_err         <= 1'b0;
                    r_sum         <= '0;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
